// ===== hw/rtl/ctk_pkg.sv =====
// Package for the command line tokenizer.
// Holds the configuration, queue entry types and the warning and error codes.
// No dependencies.
`default_nettype none

package ctk_pkg;

  // Fixed byte values and limits.
  localparam logic [7:0]  DqChar    = 8'h22;
  localparam logic [7:0]  NulChar   = 8'h00;
  localparam logic [15:0] WordLimit = 16'hFFFE;

  // Configuration register indexes.
  localparam logic [2:0] RegIgnoreQuotes = 3'd0;
  localparam logic [2:0] RegCheckParens  = 3'd1;
  localparam logic [2:0] RegSeparator    = 3'd2;
  localparam logic [2:0] RegOpenParen    = 3'd3;
  localparam logic [2:0] RegCloseParen   = 3'd4;

  // Warning codes.
  localparam logic [2:0] WarnNone       = 3'd0;
  localparam logic [2:0] WarnNestedOpen = 3'd1;
  localparam logic [2:0] WarnStrayClose = 3'd2;
  localparam logic [2:0] WarnOpenQuote  = 3'd3;
  localparam logic [2:0] WarnOpenParen  = 3'd4;

  // Error codes.
  localparam logic [1:0] ErrNone      = 2'd0;
  localparam logic [1:0] ErrEmpty     = 2'd1;
  localparam logic [1:0] ErrQuoteOpen = 2'd2;

  // Queue between front and back.
  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = 1;

  // Classification of one byte, made by the front.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       last;
    logic       is_zero;
    logic       is_quote;
    logic       is_sep;
    logic       is_open;
    logic       is_close;
  } ctk_entry_t;

  // Queue status seen by the back.
  typedef struct packed {
    logic valid;
  } ctk_hs_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ctk_front.sv =====
// Front part of the tokenizer: configuration registers and byte classification.
// Depends on ctk_pkg.
`default_nettype none

module ctk_front import ctk_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output logic            push_valid,
  input  wire logic       push_ready,
  output ctk_entry_t      push_entry
);

  logic       ignore_quotes_r;
  logic       check_parens_r;
  logic [7:0] separator_r;
  logic [7:0] open_paren_r;
  logic [7:0] close_paren_r;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ignore_quotes_r <= 1'b0;
      check_parens_r  <= 1'b0;
      separator_r     <= 8'd32;
      open_paren_r    <= 8'd40;
      close_paren_r   <= 8'd41;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegIgnoreQuotes: ignore_quotes_r <= cfg_data[0];
        RegCheckParens:  check_parens_r  <= cfg_data[0];
        RegSeparator:    separator_r     <= cfg_data;
        RegOpenParen:    open_paren_r    <= cfg_data;
        RegCloseParen:   close_paren_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Classify the byte against the configured characters.
  always_comb begin
    push_entry.in_byte  = in_byte;
    push_entry.last     = in_last;
    push_entry.is_zero  = (in_byte == NulChar);
    push_entry.is_quote = !ignore_quotes_r && (in_byte == DqChar);
    push_entry.is_sep   = (in_byte == separator_r);
    push_entry.is_open  = check_parens_r && (in_byte == open_paren_r);
    push_entry.is_close = check_parens_r && (in_byte == close_paren_r);
  end

  assign push_valid = in_valid;
  assign in_ready   = push_ready;

endmodule

`default_nettype wire

// ===== hw/rtl/ctk_queue.sv =====
// Short queue of classified bytes between front and back.
// Depends on ctk_pkg.
`default_nettype none

module ctk_queue import ctk_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push_valid,
  output logic             push_ready,
  input  wire ctk_entry_t  push_entry,
  output ctk_hs_t          pop_hs_valid,
  input  wire logic        pop_ready,
  output ctk_entry_t       pop_entry
);

  ctk_entry_t           entry_r [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QueuePtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QueuePtrW:0]   count_r, count_nxt;
  logic                 do_push, do_pop;

  assign push_ready         = (count_r != (QueuePtrW+1)'(QueueDepth));
  assign do_push            = push_valid && push_ready;
  assign pop_hs_valid.valid = (count_r != '0);
  assign do_pop             = pop_hs_valid.valid && pop_ready;
  assign pop_entry          = entry_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (QueuePtrW+1)'(do_push) - (QueuePtrW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ctk_back.sv =====
// Back part of the tokenizer: message state, word counting and the result register.
// Depends on ctk_pkg.
`default_nettype none

module ctk_back import ctk_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire ctk_hs_t    pop_hs,
  output logic            pop_ready,
  input  wire ctk_entry_t pop_entry,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_word_start,
  output logic            out_done_res,
  output logic [15:0]     out_param_count,
  output logic [2:0]      out_warning_code,
  output logic [1:0]      out_error_code
);

  // Message state.
  logic        in_quote_r, in_quote_nxt;
  logic        in_group_r, in_group_nxt;
  logic        prev_zero_r, prev_zero_nxt;
  logic        at_start_r, at_start_nxt;
  logic [15:0] word_count_r, word_count_nxt;
  logic [2:0]  first_warn_r, first_warn_nxt;
  logic        terminated_r, terminated_nxt;

  // Result register.
  logic        out_valid_r;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        word_start_r, word_start_nxt;
  logic        done_r, done_nxt;
  logic [15:0] param_r, param_nxt;
  logic [2:0]  warn_r, warn_nxt;
  logic [1:0]  err_r, err_nxt;

  logic        take;

  assign pop_ready = !out_valid_r || out_ready;
  assign take      = pop_hs.valid && pop_ready;

  // Process one classified byte against the current message state.
  always_comb begin
    logic       q, g, fin, clear, byte_zero;
    logic [2:0] fw;
    logic [15:0] wc;
    logic [7:0] ob;

    q         = in_quote_r;
    g         = in_group_r;
    fw        = first_warn_r;
    wc        = word_count_r;
    ob        = pop_entry.in_byte;
    fin       = 1'b0;
    clear     = 1'b0;
    byte_zero = 1'b0;

    prev_zero_nxt  = prev_zero_r;
    at_start_nxt   = at_start_r;
    terminated_nxt = terminated_r;
    word_start_nxt = 1'b0;
    done_nxt       = 1'b0;
    param_nxt      = '0;
    warn_nxt       = WarnNone;
    err_nxt        = ErrNone;

    priority if (terminated_r) begin
      // Pass through until the last byte of the buffer.
      clear = pop_entry.last;
    end else if (at_start_r && pop_entry.is_zero) begin
      // Empty message.
      done_nxt = 1'b1;
      err_nxt  = ErrEmpty;
      clear    = pop_entry.last;
      terminated_nxt = !pop_entry.last;
    end else if (pop_entry.is_zero || (word_count_r == WordLimit)) begin
      // Terminator or word limit: end the message with this byte unchanged.
      fin     = 1'b1;
      err_nxt = in_quote_r ? ErrQuoteOpen : ErrNone;
      clear   = pop_entry.last;
      terminated_nxt = !pop_entry.last;
    end else begin
      // Ordinary byte: replace and track quotes and groups.
      priority if (pop_entry.is_quote) begin
        ob = NulChar;
        q  = !q;
      end else if (!in_quote_r && !in_group_r && pop_entry.is_sep) begin
        ob = NulChar;
      end else if (pop_entry.is_open) begin
        if (g) begin
          if (fw == WarnNone) fw = WarnNestedOpen;
        end else begin
          g = 1'b1;
        end
        ob = NulChar;
      end else if (pop_entry.is_close) begin
        if (!g) begin
          if (fw == WarnNone) fw = WarnStrayClose;
        end else begin
          g = 1'b0;
        end
        ob = NulChar;
      end else begin
        ob = pop_entry.in_byte;
      end
      byte_zero = (ob == NulChar);
      if (!byte_zero && (at_start_r || prev_zero_r)) begin
        word_start_nxt = 1'b1;
        wc = wc + 16'd1;
      end
      prev_zero_nxt = byte_zero;
      at_start_nxt  = 1'b0;
      fin   = pop_entry.last;
      clear = pop_entry.last;
    end

    // Message end report: open quote, then open group warnings.
    if (fin) begin
      if (q && (fw == WarnNone)) fw = WarnOpenQuote;
      if (g && (fw == WarnNone)) fw = WarnOpenParen;
      done_nxt  = 1'b1;
      param_nxt = (wc != 16'd0) ? wc - 16'd1 : 16'd0;
      warn_nxt  = fw;
    end

    out_byte_nxt   = ob;
    in_quote_nxt   = q;
    in_group_nxt   = g;
    first_warn_nxt = fw;
    word_count_nxt = wc;

    // Start a new message after the last byte.
    if (clear) begin
      in_quote_nxt   = 1'b0;
      in_group_nxt   = 1'b0;
      prev_zero_nxt  = 1'b0;
      at_start_nxt   = 1'b1;
      word_count_nxt = '0;
      first_warn_nxt = WarnNone;
      terminated_nxt = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_quote_r   <= 1'b0;
      in_group_r   <= 1'b0;
      prev_zero_r  <= 1'b0;
      at_start_r   <= 1'b1;
      word_count_r <= '0;
      first_warn_r <= WarnNone;
      terminated_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (take) begin
        in_quote_r   <= in_quote_nxt;
        in_group_r   <= in_group_nxt;
        prev_zero_r  <= prev_zero_nxt;
        at_start_r   <= at_start_nxt;
        word_count_r <= word_count_nxt;
        first_warn_r <= first_warn_nxt;
        terminated_r <= terminated_nxt;
      end
      if (pop_ready) begin
        out_valid_r <= pop_hs.valid;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (take) begin
      out_byte_r   <= out_byte_nxt;
      word_start_r <= word_start_nxt;
      done_r       <= done_nxt;
      param_r      <= param_nxt;
      warn_r       <= warn_nxt;
      err_r        <= err_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = out_byte_r;
  assign out_word_start   = word_start_r;
  assign out_done_res     = done_r;
  assign out_param_count  = param_r;
  assign out_warning_code = warn_r;
  assign out_error_code   = err_r;

endmodule

`default_nettype wire

// ===== hw/rtl/command_line_tokenizer.sv =====
// Top level of the command line tokenizer: front, queue and back.
// Depends on ctk_pkg, ctk_front, ctk_queue and ctk_back.
//
//   Channel  Direction  Handshake            Payload
//   in       input      in_valid/in_ready    in_byte, in_last
//   out      output     out_valid/out_ready  out_byte, out_word_start, out_done_res,
//                                            out_param_count, out_warning_code,
//                                            out_error_code
//   cfg      input      cfg_we               cfg_index, cfg_data
//
// One byte per cycle sustained while the output is not stalled; each byte is registered
// first in the two-entry queue and then in the result register before its result shows.
// The back's message state update is one combinational step, which sets the rate.
// Reset is synchronous and active low and restores the configuration defaults.
// A stalled output fills the queue, after which in_ready drops.
`default_nettype none

module command_line_tokenizer import ctk_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic             out_word_start,
  output logic             out_done_res,
  output logic [15:0]      out_param_count,
  output logic [2:0]       out_warning_code,
  output logic [1:0]       out_error_code
);

  logic       push_valid, push_ready, pop_ready;
  ctk_entry_t push_entry, pop_entry;
  ctk_hs_t    pop_hs;

  ctk_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .in_last    (in_last),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  ctk_queue u_queue (
    .clk          (clk),
    .rst_n        (rst_n),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_entry   (push_entry),
    .pop_hs_valid (pop_hs),
    .pop_ready    (pop_ready),
    .pop_entry    (pop_entry)
  );

  ctk_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .pop_hs           (pop_hs),
    .pop_ready        (pop_ready),
    .pop_entry        (pop_entry),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_word_start   (out_word_start),
    .out_done_res     (out_done_res),
    .out_param_count  (out_param_count),
    .out_warning_code (out_warning_code),
    .out_error_code   (out_error_code)
  );

endmodule

`default_nettype wire
